### src/ppf_pkg.sv
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants for the polyline path follower
// Opcodes, register indexes, sequencer states and the iterative unit's
// control and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package ppf_pkg;

  localparam int unsigned BUDGET_W = 15;  // move_speed >> 1
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned PLEN_W   = 5;
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned SEGO_W   = 4;
  localparam int unsigned CADDR_W  = 2;

  localparam logic [OPC_W-1:0] OP_WR_WAYPOINT = 2'd0;
  localparam logic [OPC_W-1:0] OP_PLACE       = 2'd1;
  localparam logic [OPC_W-1:0] OP_TICK        = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP         = 2'd3;

  localparam logic [CADDR_W-1:0] REG_MOVE_SPEED  = 2'd0;
  localparam logic [CADDR_W-1:0] REG_PATH_LENGTH = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_SQX,
    ST_SQY,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_EVAL,
    ST_PMX,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_PMY,
    ST_DIVY_GO,
    ST_DIVY_WAIT
  } state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctrl_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } iter_stat_t;

endpackage
`default_nettype wire

### src/ppf_iter_unit.sv
// ----------------------------------------------------------------------------
// ppf_iter_unit: shared restoring square root / divider
// One compare-subtract per cycle; two radicand bits or one dividend bit a step.
// ----------------------------------------------------------------------------
`default_nettype none
module ppf_iter_unit #(
  parameter int unsigned NUM_W    = 33,
  parameter int unsigned DEN_W    = 17,
  parameter int unsigned DIV_BITS = 31
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  ppf_pkg::iter_ctrl_t     ctrl_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  output ppf_pkg::iter_stat_t     stat_o,
  output logic      [DEN_W-1:0]   res_o
);

  localparam int unsigned SQE = 2 * DEN_W;
  localparam int unsigned W   = (NUM_W > SQE) ? NUM_W : SQE;
  localparam int unsigned RW  = DEN_W + 3;
  localparam int unsigned CW  = $clog2(W + 1);

  logic [W-1:0]  num_q, num_d, res_q, res_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d, div_q, div_d;

  logic [RW-1:0] sub_a, sub_b, diff;
  logic          ge;

  always_comb begin
    if (div_q) begin
      sub_a = {rem_q[RW-2:0], num_q[W-1]};
      sub_b = RW'(den_i);
    end else begin
      sub_a = {rem_q[RW-3:0], num_q[W-1 -: 2]};
      sub_b = {res_q[RW-3:0], 2'b01};
    end
    ge   = (sub_a >= sub_b);
    diff = sub_a - sub_b;
  end

  always_comb begin
    num_d  = num_q;
    res_d  = res_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      div_d  = ctrl_i.is_div;
      rem_d  = '0;
      res_d  = '0;
      busy_d = 1'b1;
      if (ctrl_i.is_div) begin
        num_d = W'(num_i) << (W - DIV_BITS);
        cnt_d = CW'(DIV_BITS);
      end else begin
        num_d = W'(num_i) << (W - SQE);
        cnt_d = CW'(DEN_W);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff : sub_a;
      res_d = {res_q[W-2:0], ge};
      num_d = div_q ? (num_q << 1) : (num_q << 2);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    res_q <= res_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.done   = done_q;
  assign stat_o.rem_nz = (rem_q != '0);
  assign res_o         = res_q[DEN_W-1:0];

endmodule
`default_nettype wire

### src/polyline_path_follower_top.sv
// ----------------------------------------------------------------------------
// polyline_path_follower_top: moves a point along a stored waypoint polyline
// Waypoint writes, point placement and fixed-budget ticks that walk segments
// with an integer distance and an exact per-axis quotient.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  in      | in  | in_valid_i/in_ready_o  | opcode, waypoint_index, coord_x/y
//  out     | out | out_valid_o/out_ready_i| pos_x/y, segment_index, finished,
//          |     |                        | rearm
//  cfg     | in  | cfg_we_i (no wait)     | cfg_addr_i, cfg_wdata_i
//
// Write, place, no-op and idle-tick beats complete on acceptance; the
// result is valid on the next cycle. A tick with work walks each segment
// through read, load, two squares, root start, the root steps and compare,
// and, on a partial segment, adds two divisions (product, start, divide
// steps), one per axis, on the shared root/divide unit.
// Reset clears point, segment and speed, sets path length to 1; waypoints are not cleared.
// in_ready_o is high only while idle with the result register free or draining.
// ----------------------------------------------------------------------------
`default_nettype none
module polyline_path_follower_top #(
  parameter int unsigned MAX_WAYPOINTS = 16,
  parameter int unsigned COORD_BITS    = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ppf_pkg::CADDR_W-1:0]   cfg_addr_i,
  input  wire logic [ppf_pkg::SPEED_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ppf_pkg::OPC_W-1:0]     opcode_i,
  input  wire logic [ppf_pkg::IDX_W-1:0]     waypoint_index_i,
  input  wire logic [COORD_BITS-1:0]         coord_x_i,
  input  wire logic [COORD_BITS-1:0]         coord_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [COORD_BITS-1:0]         pos_x_o,
  output logic      [COORD_BITS-1:0]         pos_y_o,
  output logic      [ppf_pkg::SEGO_W-1:0]    segment_index_o,
  output logic                               finished_o,
  output logic                               rearm_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned SW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned BW  = ppf_pkg::BUDGET_W;
  localparam int unsigned MBW = (C > BW) ? C : BW;
  localparam int unsigned MW  = C + MBW;
  localparam int unsigned SQW = 2 * C + 1;
  localparam int unsigned PW  = BW + C;
  localparam int unsigned AW  = (SQW > PW) ? SQW : PW;
  localparam int unsigned DW  = C + 1;
  localparam int unsigned CW  = (DW > BW) ? DW : BW;

  // config
  logic [ppf_pkg::SPEED_W-1:0] speed_q;
  logic [ppf_pkg::PLEN_W-1:0]  plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      plen_q  <= ppf_pkg::PLEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ppf_pkg::REG_MOVE_SPEED:  speed_q <= cfg_wdata_i;
        ppf_pkg::REG_PATH_LENGTH: plen_q  <= cfg_wdata_i[ppf_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective path length, clamped to the memory depth
  int unsigned len_eff;
  assign len_eff = (32'(plen_q) > MAX_WAYPOINTS) ? MAX_WAYPOINTS : 32'(plen_q);

  // state
  ppf_pkg::state_e state_q, state_d;
  logic [C-1:0]  px_q, px_d, py_q, py_d;
  logic [SW-1:0] seg_q, seg_d;
  logic [BW-1:0] bud_q, bud_d;
  logic [C-1:0]  adx_q, adx_d, ady_q, ady_d;
  logic          nx_q, nx_d, ny_q, ny_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [DW-1:0] dist_q, dist_d;
  logic          ov_q, ov_d, fin_q, fin_d, rea_q, rea_d;

  // waypoint memory: x low, y high
  logic [2*C-1:0] wp_mem [MAX_WAYPOINTS];
  logic [2*C-1:0] wp_rd_q;
  logic           wp_we, wp_re;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;
  assign wp_we  = in_acc && (opcode_i == ppf_pkg::OP_WR_WAYPOINT)
                  && (32'(waypoint_index_i) < MAX_WAYPOINTS);

  always_ff @(posedge clk_i) begin
    if (wp_we) wp_mem[SW'(waypoint_index_i)] <= {coord_y_i, coord_x_i};
    if (wp_re) wp_rd_q <= wp_mem[seg_q];
  end

  logic [C-1:0] tx, ty;
  assign tx = wp_rd_q[C-1:0];
  assign ty = wp_rd_q[2*C-1:C];

  // shared multiplier
  logic [C-1:0]   mul_a;
  logic [MBW-1:0] mul_b;
  logic [MW-1:0]  mul_p;
  logic           mul_y, mul_sq;
  assign mul_a = mul_y ? ady_q : adx_q;
  assign mul_b = mul_sq ? MBW'(mul_a) : MBW'(bud_q);
  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // shared root / divide unit
  ppf_pkg::iter_ctrl_t it_ctrl;
  ppf_pkg::iter_stat_t it_stat;
  logic [DW-1:0]       it_res;

  ppf_iter_unit #(
    .NUM_W    (AW),
    .DEN_W    (DW),
    .DIV_BITS (PW)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (it_ctrl),
    .num_i  (acc_q),
    .den_i  (dist_q),
    .stat_o (it_stat),
    .res_o  (it_res)
  );

  // floor-signed step from the unit quotient
  logic [C-1:0] q_mag, q_adj;
  logic         q_neg;
  assign q_mag = it_res[C-1:0];
  assign q_neg = (state_q == ppf_pkg::ST_DIVY_WAIT) ? ny_q : nx_q;
  assign q_adj = q_neg ? (C'(0) - (q_mag + C'(it_stat.rem_nz))) : q_mag;

  logic [DW-1:0] dfx, dfy;
  assign dfx = {1'b0, tx} - {1'b0, px_q};
  assign dfy = {1'b0, ty} - {1'b0, py_q};

  logic bud_lt, seg_last;
  assign bud_lt   = CW'(bud_q) < CW'(dist_q);
  assign seg_last = (32'(seg_q) + 32'd1) == len_eff;

  logic tick_idle;
  assign tick_idle = (speed_q[ppf_pkg::SPEED_W-1:1] == '0) || (32'(seg_q) >= len_eff);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppf_pkg::ST_IDLE:
        if (in_acc && (opcode_i == ppf_pkg::OP_TICK) && !tick_idle) state_d = ppf_pkg::ST_RD;
      ppf_pkg::ST_RD:        state_d = ppf_pkg::ST_LOAD;
      ppf_pkg::ST_LOAD:      state_d = ppf_pkg::ST_SQX;
      ppf_pkg::ST_SQX:       state_d = ppf_pkg::ST_SQY;
      ppf_pkg::ST_SQY:       state_d = ppf_pkg::ST_SQRT_GO;
      ppf_pkg::ST_SQRT_GO:   state_d = ppf_pkg::ST_SQRT_WAIT;
      ppf_pkg::ST_SQRT_WAIT: if (it_stat.done) state_d = ppf_pkg::ST_EVAL;
      ppf_pkg::ST_EVAL: begin
        if (bud_lt) state_d = ppf_pkg::ST_PMX;
        else if ((bud_q == BW'(dist_q)) || seg_last) state_d = ppf_pkg::ST_IDLE;
        else state_d = ppf_pkg::ST_RD;
      end
      ppf_pkg::ST_PMX:       state_d = ppf_pkg::ST_DIVX_GO;
      ppf_pkg::ST_DIVX_GO:   state_d = ppf_pkg::ST_DIVX_WAIT;
      ppf_pkg::ST_DIVX_WAIT: if (it_stat.done) state_d = ppf_pkg::ST_PMY;
      ppf_pkg::ST_PMY:       state_d = ppf_pkg::ST_DIVY_GO;
      ppf_pkg::ST_DIVY_GO:   state_d = ppf_pkg::ST_DIVY_WAIT;
      ppf_pkg::ST_DIVY_WAIT: if (it_stat.done) state_d = ppf_pkg::ST_IDLE;
      default:               state_d = ppf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    px_d    = px_q;
    py_d    = py_q;
    seg_d   = seg_q;
    bud_d   = bud_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    acc_d   = acc_q;
    dist_d  = dist_q;
    fin_d   = fin_q;
    rea_d   = rea_q;
    ov_d    = ov_q && !out_ready_i;
    wp_re   = 1'b0;
    mul_y   = 1'b0;
    mul_sq  = 1'b1;
    it_ctrl = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ppf_pkg::ST_IDLE: begin
        in_ready_o = !ov_q || out_ready_i;
        if (in_acc) begin
          fin_d = 1'b0;
          rea_d = 1'b0;
          bud_d = speed_q[ppf_pkg::SPEED_W-1:1];
          if (opcode_i == ppf_pkg::OP_PLACE) begin
            px_d  = coord_x_i;
            py_d  = coord_y_i;
            seg_d = '0;
          end
          // a tick with work leaves the result for later
          ov_d = !((opcode_i == ppf_pkg::OP_TICK) && !tick_idle);
        end
      end
      ppf_pkg::ST_RD: wp_re = 1'b1;
      ppf_pkg::ST_LOAD: begin
        nx_d  = dfx[C];
        ny_d  = dfy[C];
        adx_d = dfx[C] ? C'(-dfx) : dfx[C-1:0];
        ady_d = dfy[C] ? C'(-dfy) : dfy[C-1:0];
      end
      ppf_pkg::ST_SQX: acc_d = AW'(mul_p);
      ppf_pkg::ST_SQY: begin
        mul_y = 1'b1;
        acc_d = acc_q + AW'(mul_p);
      end
      ppf_pkg::ST_SQRT_GO: it_ctrl.start = 1'b1;
      ppf_pkg::ST_SQRT_WAIT: if (it_stat.done) dist_d = it_res;
      ppf_pkg::ST_EVAL: begin
        if (!bud_lt) begin
          bud_d = bud_q - BW'(dist_q);
          px_d  = tx;
          py_d  = ty;
          if ((bud_q == BW'(dist_q)) || seg_last) begin
            fin_d = seg_last;
            rea_d = !seg_last;
            ov_d  = 1'b1;
          end else begin
            seg_d = seg_q + 1'b1;
          end
        end
      end
      ppf_pkg::ST_PMX: begin
        mul_sq = 1'b0;
        acc_d  = AW'(mul_p);
      end
      ppf_pkg::ST_DIVX_GO: begin
        it_ctrl.start  = 1'b1;
        it_ctrl.is_div = 1'b1;
      end
      ppf_pkg::ST_DIVX_WAIT: if (it_stat.done) px_d = px_q + q_adj;
      ppf_pkg::ST_PMY: begin
        mul_sq = 1'b0;
        mul_y  = 1'b1;
        acc_d  = AW'(mul_p);
      end
      ppf_pkg::ST_DIVY_GO: begin
        it_ctrl.start  = 1'b1;
        it_ctrl.is_div = 1'b1;
      end
      ppf_pkg::ST_DIVY_WAIT: begin
        if (it_stat.done) begin
          py_d  = py_q + q_adj;
          rea_d = 1'b1;
          ov_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppf_pkg::ST_IDLE;
      px_q    <= '0;
      py_q    <= '0;
      seg_q   <= '0;
      ov_q    <= 1'b0;
      fin_q   <= 1'b0;
      rea_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      px_q    <= px_d;
      py_q    <= py_d;
      seg_q   <= seg_d;
      ov_q    <= ov_d;
      fin_q   <= fin_d;
      rea_q   <= rea_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bud_q  <= bud_d;
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    acc_q  <= acc_d;
    dist_q <= dist_d;
  end

  // point and segment hold while a result waits: the next beat needs the slot
  assign out_valid_o     = ov_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign segment_index_o = ppf_pkg::SEGO_W'(seg_q);
  assign finished_o      = fin_q;
  assign rearm_o         = rea_q;

  // checks
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ppf_pkg::ST_IDLE) |-> !ov_q)
    else $error("result pending while sequencer busy");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(fin_q && rea_q))
    else $error("finished and rearm both set");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_stat.done |-> (state_q == ppf_pkg::ST_SQRT_WAIT || state_q == ppf_pkg::ST_DIVX_WAIT
                      || state_q == ppf_pkg::ST_DIVY_WAIT))
    else $error("iterative unit done outside a wait state");

endmodule
`default_nettype wire

### sim/polyline_path_follower_top_tb.sv
// ----------------------------------------------------------------------------
// polyline_path_follower_top_tb: self-checking bench for the path follower
// Drives waypoint writes, placements, ticks and no-ops through the valid/ready input,
// predicts every result beat with an integer walk model and compares each
// output beat field by field. Both channels idle in random bursts but for the last phase.
// ----------------------------------------------------------------------------
`default_nettype none
module polyline_path_follower_top_tb;

  localparam int unsigned NWP    = 16;
  localparam int unsigned SETTLE = 600;  // worst tick: 16 roots plus two divides

  typedef struct packed {
    logic [ppf_pkg::OPC_W-1:0] op;
    logic [ppf_pkg::IDX_W-1:0] idx;
    logic [15:0]               x;
    logic [15:0]               y;
  } cmd_t;

  typedef struct packed {
    logic [15:0]                px;
    logic [15:0]                py;
    logic [ppf_pkg::SEGO_W-1:0] seg;
    logic                       fin;
    logic                       rearm;
  } pose_t;

  typedef struct packed {
    cmd_t  c;
    pose_t e;
  } beat_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [ppf_pkg::CADDR_W-1:0]  cfg_addr = '0;
  logic [ppf_pkg::SPEED_W-1:0]  cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  cmd_t                         in_cmd = '0;
  pose_t                        in_exp = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [15:0]                  pos_x, pos_y;
  logic [ppf_pkg::SEGO_W-1:0]   seg_idx;
  logic                         fin, rearm;

  beat_t pending[$];   // queued, not yet driven
  pose_t poses[$];     // accepted, result not yet seen
  bit    in_fire;
  bit    quiet = 0;    // no idling in the last phase
  int    errors = 0;
  int    in_gap = 0, out_gap = 0;

  // predictor state
  logic [15:0] pt_x, pt_y;
  logic [3:0]  cur_seg;
  logic [15:0] speed;
  logic [4:0]  plen;
  logic [15:0] wp_x[NWP], wp_y[NWP];

  polyline_path_follower_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (in_cmd.op),
    .waypoint_index_i(in_cmd.idx),
    .coord_x_i       (in_cmd.x),
    .coord_y_i       (in_cmd.y),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y),
    .segment_index_o (seg_idx),
    .finished_o      (fin),
    .rearm_o         (rearm)
  );

  initial forever #5 clk = ~clk;

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // One tick: walk segments with the budget, carrying leftovers forward.
  function automatic void walk(output logic f, output logic r);
    longint budget, cx, cy, tx, ty, dx, dy, seg_len;
    int     len;
    bit     last, done;
    f = 1'b0;
    r = 1'b0;
    budget = longint'(speed >> 1);
    len = (plen > NWP) ? NWP : int'(plen);
    if (budget <= 0 || cur_seg >= len) return;
    cx = pt_x;
    cy = pt_y;
    done = 0;
    while (!done) begin
      tx = wp_x[cur_seg];
      ty = wp_y[cur_seg];
      dx = tx - cx;
      dy = ty - cy;
      seg_len = isqrt(dx * dx + dy * dy);
      last = (cur_seg == len - 1);
      if (budget < seg_len) begin
        pt_x = 16'(cx + floor_quot(budget * dx, seg_len));
        pt_y = 16'(cy + floor_quot(budget * dy, seg_len));
        r = 1'b1;
        done = 1;
      end else begin
        budget = budget - seg_len;
        if (budget <= 0 || last) begin
          pt_x = 16'(tx);
          pt_y = 16'(ty);
          if (last) f = 1'b1;
          else r = 1'b1;
          done = 1;
        end else begin
          cur_seg = cur_seg + 4'd1;
          cx = tx;
          cy = ty;
        end
      end
    end
  endfunction

  // Apply a command to the predictor and queue it with its expected pose.
  task automatic issue(input logic [1:0] op, input logic [3:0] idx,
                       input logic [15:0] x, input logic [15:0] y);
    beat_t b;
    logic  f, r;
    f = 1'b0;
    r = 1'b0;
    case (op)
      ppf_pkg::OP_WR_WAYPOINT: begin
        wp_x[idx] = x;
        wp_y[idx] = y;
      end
      ppf_pkg::OP_PLACE: begin
        pt_x = x;
        pt_y = y;
        cur_seg = '0;
      end
      ppf_pkg::OP_TICK: walk(f, r);
      default: ;
    endcase
    b.c = '{op: op, idx: idx, x: x, y: y};
    b.e = '{px: pt_x, py: pt_y, seg: cur_seg, fin: f, rearm: r};
    pending.push_back(b);
  endtask

  // Random item: mostly ticks along a path, some rewrites, placements, no-ops.
  task automatic random_item();
    int          k, w;
    logic [15:0] x, y;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      if ($urandom_range(0, 2) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = pt_x + 16'($urandom_range(0, 4000)) - 16'd2000;
        y = pt_y + 16'($urandom_range(0, 4000)) - 16'd2000;
      end
      issue(ppf_pkg::OP_WR_WAYPOINT, 4'($urandom), x, y);
    end else if (k < 17) begin
      w = $urandom_range(0, NWP - 1);
      if ($urandom_range(0, 1) == 0) begin
        issue(ppf_pkg::OP_PLACE, 4'($urandom), wp_x[w], wp_y[w]);
      end else begin
        issue(ppf_pkg::OP_PLACE, 4'($urandom), 16'($urandom), 16'($urandom));
      end
    end else if (k < 19) begin
      issue(ppf_pkg::OP_NOP, 4'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      issue(ppf_pkg::OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Waits for the block to drain completely, then lets it settle.
  task automatic drain();
    while (pending.size() != 0 || in_valid || poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ppf_pkg::CADDR_W-1:0] a, input logic [15:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (a == ppf_pkg::REG_MOVE_SPEED) speed = d;
    else plen = d[4:0];
  endtask

  // Input driver: presents the next queued beat, with random idle bursts.
  always @(negedge clk) begin
    logic  v;
    beat_t b;
    v = in_valid;
    if (in_valid && in_fire) v = 1'b0;
    if (!v && rst_n) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending.size() != 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 6);
        end else begin
          b = pending.pop_front();
          in_cmd <= b.c;
          in_exp <= b.e;
          v = 1'b1;
        end
      end
    end
    in_valid <= v;
    // result side back-pressure
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: log accepted input beats, check every result beat.
  always @(posedge clk) begin
    pose_t e;
    in_fire <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) poses.push_back(in_exp);
    if (rst_n && out_valid && out_ready) begin
      if (poses.size() == 0) begin
        $error("result beat with no pending item");
        errors++;
      end else begin
        e = poses.pop_front();
        if (pos_x !== e.px) begin
          $error("pos_x exp %0d got %0d", e.px, pos_x); errors++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y exp %0d got %0d", e.py, pos_y); errors++;
        end
        if (seg_idx !== e.seg) begin
          $error("segment_index exp %0d got %0d", e.seg, seg_idx); errors++;
        end
        if (fin !== e.fin) begin
          $error("finished exp %0d got %0d", e.fin, fin); errors++;
        end
        if (rearm !== e.rearm) begin
          $error("rearm exp %0d got %0d", e.rearm, rearm); errors++;
        end
      end
    end
  end

  initial begin
    logic [15:0] speeds[12] = '{16'd65535, 16'd1, 16'd200, 16'd3000, 16'd0, 16'd40,
                               16'd65535, 16'd9000, 16'd2, 16'd500, 16'd30000, 16'd777};
    logic [4:0]  lens[12]   = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd17,
                               5'd5, 5'd16, 5'd3, 5'd16, 5'd8, 5'd12};
    pt_x = '0;
    pt_y = '0;
    cur_seg = '0;
    speed = '0;
    plen = 5'd1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fill every slot, exact arrival, partial step, extremes, no-op.
    reg_write(ppf_pkg::REG_MOVE_SPEED, 16'd10);
    reg_write(ppf_pkg::REG_PATH_LENGTH, 16'd16);
    issue(ppf_pkg::OP_WR_WAYPOINT, 4'd0, 16'd3, 16'd4);
    issue(ppf_pkg::OP_WR_WAYPOINT, 4'd1, 16'd3, 16'd14);
    issue(ppf_pkg::OP_WR_WAYPOINT, 4'd2, 16'd65535, 16'd65535);
    issue(ppf_pkg::OP_WR_WAYPOINT, 4'd3, 16'd0, 16'd65535);
    issue(ppf_pkg::OP_WR_WAYPOINT, 4'd4, 16'd65535, 16'd0);
    issue(ppf_pkg::OP_WR_WAYPOINT, 4'd5, 16'd0, 16'd0);
    for (int i = 6; i < NWP; i++) begin
      issue(ppf_pkg::OP_WR_WAYPOINT, 4'(i), 16'(i * 50), 16'(i * 30));
    end
    issue(ppf_pkg::OP_PLACE, 4'd15, 16'd0, 16'd0);
    issue(ppf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0);          // lands exactly on waypoint 0
    issue(ppf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0);          // zero-length hop, then partial
    issue(ppf_pkg::OP_TICK, 4'd0, 16'hFFFF, 16'hFFFF);    // reaches waypoint 1, no leftover
    issue(ppf_pkg::OP_NOP, 4'd15, 16'hFFFF, 16'hFFFF);
    issue(ppf_pkg::OP_PLACE, 4'd0, 16'hFFFF, 16'hFFFF);
    issue(ppf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0);          // negative direction on both axes
    drain();

    for (int p = 0; p < 12; p++) begin
      reg_write(ppf_pkg::REG_MOVE_SPEED, (p == 11) ? 16'($urandom) : speeds[p]);
      reg_write(ppf_pkg::REG_PATH_LENGTH, 16'(lens[p]));
      if (p == 11) quiet = 1;
      issue(ppf_pkg::OP_PLACE, 4'd0, wp_x[NWP - 1], wp_y[0]);
      for (int n = 0; n < 140; n++) random_item();
      drain();
    end

    if (errors == 0) $display("polyline_path_follower_top: match");
    else $display("polyline_path_follower_top: mismatch");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("polyline_path_follower_top: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
